// ===== hdl/pdn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pdn_pkg;

  // Field and register widths
  localparam int ERRW   = 32;                 // error input width
  localparam int GW     = 16;                 // gain / limit width (Q8.8)
  localparam int NREG   = 7;
  localparam int ERR_FRAC_BITS_DEF = 16;

  // Lane datapath widths
  localparam int PRODW  = GW + 1 + ERRW;      // signed gain * error
  localparam int ACCW   = PRODW + 1;          // signed sum of two products
  localparam int MAGW   = ACCW - 1;           // magnitude of the sum
  localparam int SPLIT  = 25;                 // low half of the square split
  localparam int HIW    = MAGW - SPLIT;
  localparam int SQW    = 2 * MAGW;           // exact square
  localparam int SUMW   = SQW + 2;            // sum of three squares

  // Clipping path widths
  localparam int BW     = 31;                 // normalized magnitude
  localparam int KW     = 5;                  // normalizing shift
  localparam int SQIW   = 64;                 // radicand
  localparam int ROOTW  = SQIW / 2;
  localparam int PRW    = BW + GW;            // B * limit
  localparam int NUMW   = PRW + 8;            // dividend
  localparam int QW     = 25;                 // quotient bits
  localparam int OUTW   = 25;                 // Q8.16 output
  localparam int UMW    = OUTW - 1;           // output magnitude
  localparam int NLANE  = 3;

  // Register map
  typedef enum logic [2:0] {
    REG_POS_GAIN_X = 3'd0,
    REG_POS_GAIN_Y = 3'd1,
    REG_POS_GAIN_Z = 3'd2,
    REG_VEL_GAIN_X = 3'd3,
    REG_VEL_GAIN_Y = 3'd4,
    REG_VEL_GAIN_Z = 3'd5,
    REG_MAX_ACCEL  = 3'd6
  } reg_idx_t;

  localparam logic [GW-1:0] RST_POS_GAIN_X = 16'd2048;
  localparam logic [GW-1:0] RST_POS_GAIN_Y = 16'd2048;
  localparam logic [GW-1:0] RST_POS_GAIN_Z = 16'd3840;
  localparam logic [GW-1:0] RST_VEL_GAIN_X = 16'd384;
  localparam logic [GW-1:0] RST_VEL_GAIN_Y = 16'd384;
  localparam logic [GW-1:0] RST_VEL_GAIN_Z = 16'd1024;
  localparam logic [GW-1:0] RST_MAX_ACCEL  = 16'd5120;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic [SQW-1:0]  sq;
    logic [MAGW-1:0] mag;
    logic            neg;
    logic [UMW-1:0]  um;     // rounded, saturated unclipped magnitude
  } lane_out_t;

  // Side data carried through the square root
  typedef struct packed {
    logic                        clip;
    logic [NLANE-1:0]            neg;
    logic [NLANE-1:0][UMW-1:0]   um;
    logic [NLANE-1:0][PRW-1:0]   prod;
  } sq_side_t;

  // Side data carried through each divider
  typedef struct packed {
    logic           nz;
    logic           clip;
    logic           neg;
    logic [UMW-1:0] um;
  } div_side_t;

endpackage
`default_nettype wire

// ===== hdl/pd_accel_with_norm_clip.sv =====
`timescale 1ns / 1ps
`default_nettype none
// PD feedback acceleration with Euclidean norm limit. Each request carries
// three position errors and three velocity errors (signed, ERR_FRAC_BITS
// fraction bits); three axis lanes form -(pos_gain*perr + vel_gain*verr)
// exactly, the merge stage compares the squared norm with max_accel^2 and,
// when it is exceeded, rescales all axes by max_accel/norm through a
// pipelined square root and three pipelined dividers. The result is signed
// Q8.16 per axis plus a clip flag in tuser. The pipeline takes one request
// per clock while the output is not stalled; it has 4 lane stages, 4 merge
// stages, 32 square-root stages, 25 divider stages and the output register.
// Gains and limit are unsigned Q8.8 registers at byte addresses 0x00..0x18.
module pd_accel_with_norm_clip
  import pdn_pkg::*;
#(
  parameter int ERR_FRAC_BITS = ERR_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // perr_x, perr_y, perr_z, verr_x, verr_y, verr_z (32 bits each)
  input  wire logic [191:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // acc_x, acc_y, acc_z (25 bits each), 5 zero pad bits
  output logic [79:0]       m_tdata,
  // was_clipped
  output logic [0:0]        m_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SIDEW = $bits(sq_side_t);
  localparam int DSW   = $bits(div_side_t);

  // Configuration registers
  logic [GW-1:0] pos_gain [NLANE];
  logic [GW-1:0] vel_gain [NLANE];
  logic [GW-1:0] max_accel;
  logic          cfg_wr;
  reg_idx_t      widx;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain[0] <= RST_POS_GAIN_X;
      pos_gain[1] <= RST_POS_GAIN_Y;
      pos_gain[2] <= RST_POS_GAIN_Z;
      vel_gain[0] <= RST_VEL_GAIN_X;
      vel_gain[1] <= RST_VEL_GAIN_Y;
      vel_gain[2] <= RST_VEL_GAIN_Z;
      max_accel   <= RST_MAX_ACCEL;
    end else if (cfg_wr) begin
      unique case (widx)
        REG_POS_GAIN_X: pos_gain[0] <= pwdata[GW-1:0];
        REG_POS_GAIN_Y: pos_gain[1] <= pwdata[GW-1:0];
        REG_POS_GAIN_Z: pos_gain[2] <= pwdata[GW-1:0];
        REG_VEL_GAIN_X: vel_gain[0] <= pwdata[GW-1:0];
        REG_VEL_GAIN_Y: vel_gain[1] <= pwdata[GW-1:0];
        REG_VEL_GAIN_Z: vel_gain[2] <= pwdata[GW-1:0];
        REG_MAX_ACCEL:  max_accel   <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (widx)
      REG_POS_GAIN_X: prdata = {16'd0, pos_gain[0]};
      REG_POS_GAIN_Y: prdata = {16'd0, pos_gain[1]};
      REG_POS_GAIN_Z: prdata = {16'd0, pos_gain[2]};
      REG_VEL_GAIN_X: prdata = {16'd0, vel_gain[0]};
      REG_VEL_GAIN_Y: prdata = {16'd0, vel_gain[1]};
      REG_VEL_GAIN_Z: prdata = {16'd0, vel_gain[2]};
      REG_MAX_ACCEL:  prdata = {16'd0, max_accel};
      default:        prdata = '0;
    endcase
  end

  // Squared limit in the units of the squared sums
  logic [SUMW-1:0] limsq;
  always_ff @(posedge clk) begin
    limsq <= SUMW'(32'(max_accel) * 32'(max_accel)) << (2 * ERR_FRAC_BITS);
  end

  // Pipeline advance: stalls only when a finished request meets a full,
  // untaken output register
  logic last_valid, adv, out_load;
  assign adv      = !last_valid || !m_tvalid || m_tready;
  assign s_tready = adv;
  assign out_load = last_valid && (!m_tvalid || m_tready);

  // Valid bits for lane and merge stages (1..8)
  logic [8:1] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[7:1], s_tvalid};
    end
  end

  // Axis lanes
  lane_out_t lo [NLANE];
  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    pdn_lane #(.ERR_FRAC_BITS(ERR_FRAC_BITS)) u_lane (
      .clk (clk),
      .en  (adv),
      .pe  (s_tdata[ERRW*i +: ERRW]),
      .ve  (s_tdata[ERRW*(i+NLANE) +: ERRW]),
      .pg  (pos_gain[i]),
      .vg  (vel_gain[i]),
      .lo  (lo[i])
    );
  end

  // Normalizing shift: bit length of the largest magnitude equals that of
  // the OR of all three
  logic [MAGW-1:0] ormag;
  logic [KW-1:0]   k_c;
  always_comb begin
    ormag = lo[0].mag | lo[1].mag | lo[2].mag;
    k_c   = '0;
    for (int i = BW; i < MAGW; i++) begin
      if (ormag[i]) k_c = KW'(i - BW + 1);
    end
  end

  // Stage 5: sum of squares, shift amount
  logic [SUMW-1:0]  sumsq5;
  logic [KW-1:0]    k5;
  logic [MAGW-1:0]  mag5 [NLANE];
  logic [NLANE-1:0] neg5;
  logic [UMW-1:0]   um5  [NLANE];
  always_ff @(posedge clk) begin
    if (adv) begin
      sumsq5 <= SUMW'(lo[0].sq) + SUMW'(lo[1].sq) + SUMW'(lo[2].sq);
      k5     <= k_c;
      for (int i = 0; i < NLANE; i++) begin
        mag5[i] <= lo[i].mag;
        neg5[i] <= lo[i].neg;
        um5[i]  <= lo[i].um;
      end
    end
  end

  // Stage 6: clip decision, normalized magnitudes
  logic             clip6;
  logic [BW-1:0]    b6   [NLANE];
  logic [NLANE-1:0] neg6;
  logic [UMW-1:0]   um6  [NLANE];
  always_ff @(posedge clk) begin
    if (adv) begin
      clip6 <= sumsq5 > limsq;
      neg6  <= neg5;
      for (int i = 0; i < NLANE; i++) begin
        b6[i]  <= BW'(mag5[i] >> k5);
        um6[i] <= um5[i];
      end
    end
  end

  // Stage 7: squares and scaled numerators
  logic             clip7;
  logic [2*BW-1:0]  bb7   [NLANE];
  logic [PRW-1:0]   prod7 [NLANE];
  logic [NLANE-1:0] neg7;
  logic [UMW-1:0]   um7   [NLANE];
  always_ff @(posedge clk) begin
    if (adv) begin
      clip7 <= clip6;
      neg7  <= neg6;
      for (int i = 0; i < NLANE; i++) begin
        bb7[i]   <= b6[i] * b6[i];
        prod7[i] <= PRW'(b6[i]) * PRW'(max_accel);
        um7[i]   <= um6[i];
      end
    end
  end

  // Stage 8: radicand
  logic [SQIW-1:0] s8;
  sq_side_t        side8;
  always_ff @(posedge clk) begin
    if (adv) begin
      s8         <= SQIW'(bb7[0]) + SQIW'(bb7[1]) + SQIW'(bb7[2]);
      side8.clip <= clip7;
      side8.neg  <= neg7;
      for (int i = 0; i < NLANE; i++) begin
        side8.um[i]   <= um7[i];
        side8.prod[i] <= prod7[i];
      end
    end
  end

  // Square root of the normalized squared norm
  logic             sq_valid;
  logic [ROOTW-1:0] nroot;
  logic [SIDEW-1:0] sq_side_raw;
  sq_side_t         sq_side;

  pdn_isqrt #(.PW(SIDEW)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vld[8]),
    .rad       (s8),
    .in_side   (SIDEW'(side8)),
    .out_valid (sq_valid),
    .root      (nroot),
    .out_side  (sq_side_raw)
  );

  assign sq_side = sq_side_t'(sq_side_raw);

  // Valid bits alongside the dividers
  logic [QW-1:0] dvld;
  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= '0;
    end else if (adv) begin
      dvld <= {dvld[QW-2:0], sq_valid};
    end
  end
  assign last_valid = dvld[QW-1];

  // Per-axis dividers
  logic [QW-1:0] quo [NLANE];
  div_side_t     dside [NLANE];
  for (genvar i = 0; i < NLANE; i++) begin : g_div
    div_side_t      din;
    logic [DSW-1:0] dout;

    always_comb begin
      din.nz   = |nroot;
      din.clip = sq_side.clip;
      din.neg  = sq_side.neg[i];
      din.um   = sq_side.um[i];
    end

    pdn_div #(.PW(DSW)) u_div (
      .clk      (clk),
      .en       (adv),
      .num      ({sq_side.prod[i], 8'd0}),
      .den      (nroot),
      .in_side  (DSW'(din)),
      .quo      (quo[i]),
      .out_side (dout)
    );

    assign dside[i] = div_side_t'(dout);
  end

  // Output select, saturate and sign
  logic [OUTW-1:0] acc_c [NLANE];
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      logic [QW-1:0]  m;
      logic [UMW-1:0] ms;
      if (dside[i].clip) begin
        m = dside[i].nz ? quo[i] : '0;
      end else begin
        m = {1'b0, dside[i].um};
      end
      ms       = m[QW-1] ? {UMW{1'b1}} : m[UMW-1:0];
      acc_c[i] = dside[i].neg ? -{1'b0, ms} : {1'b0, ms};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'd0, acc_c[2], acc_c[1], acc_c[0]};
      m_tuser <= dside[0].clip;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pdn_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pdn_lane
  import pdn_pkg::*;
#(
  parameter int ERR_FRAC_BITS = ERR_FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [ERRW-1:0] pe,
  input  wire logic signed [ERRW-1:0] ve,
  input  wire logic [GW-1:0]          pg,
  input  wire logic [GW-1:0]          vg,
  output lane_out_t                   lo
);

  localparam int SH = ERR_FRAC_BITS - 8;

  logic signed [PRODW-1:0] pp, vp;
  logic signed [ACCW-1:0]  acc;
  logic [ACCW-1:0]         acc_abs;
  logic [MAGW-1:0]         mag2, mag3;
  logic                    neg2, neg3;
  logic [2*HIW-1:0]        hh;
  logic [HIW+SPLIT-1:0]    hl;
  logic [2*SPLIT-1:0]      ll;
  logic [MAGW:0]           rnd;
  logic [UMW-1:0]          um_c, um3;

  // Stage 1: gain products
  always_ff @(posedge clk) begin
    if (en) begin
      pp <= $signed({1'b0, pg}) * pe;
      vp <= $signed({1'b0, vg}) * ve;
    end
  end

  // Stage 2: negated sum, sign and magnitude
  always_comb begin
    acc     = -(ACCW'(pp) + ACCW'(vp));
    acc_abs = acc[ACCW-1] ? -acc : acc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= acc[ACCW-1];
      mag2 <= acc_abs[MAGW-1:0];
    end
  end

  // Unclipped path: round half away from zero to Q8.16, then saturate
  generate
    if (SH == 0) begin : g_noround
      assign rnd = {1'b0, mag2};
    end else begin : g_round
      assign rnd = ({1'b0, mag2} + ((MAGW+1)'(1) << (SH - 1))) >> SH;
    end
  endgenerate

  assign um_c = (|rnd[MAGW:UMW]) ? {UMW{1'b1}} : rnd[UMW-1:0];

  // Stage 3: partial products of the square
  always_ff @(posedge clk) begin
    if (en) begin
      hh   <= mag2[MAGW-1:SPLIT] * mag2[MAGW-1:SPLIT];
      hl   <= mag2[MAGW-1:SPLIT] * mag2[SPLIT-1:0];
      ll   <= mag2[SPLIT-1:0] * mag2[SPLIT-1:0];
      mag3 <= mag2;
      neg3 <= neg2;
      um3  <= um_c;
    end
  end

  // Stage 4: combine partials
  always_ff @(posedge clk) begin
    if (en) begin
      lo.sq  <= (SQW'(hh) << (2 * SPLIT)) + (SQW'(hl) << (SPLIT + 1)) + SQW'(ll);
      lo.mag <= mag3;
      lo.neg <= neg3;
      lo.um  <= um3;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pdn_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pdn_isqrt
  import pdn_pkg::*;
#(
  parameter int PW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [SQIW-1:0]  rad,
  input  wire logic [PW-1:0]    in_side,
  output logic                  out_valid,
  output logic [ROOTW-1:0]      root,
  output logic [PW-1:0]         out_side
);

  logic [SQIW-1:0] v_q    [ROOTW+1];
  logic [SQIW-1:0] r_q    [ROOTW+1];
  logic [PW-1:0]   side_q [ROOTW+1];
  logic            vld_q  [ROOTW+1];

  assign v_q[0]    = rad;
  assign r_q[0]    = '0;
  assign side_q[0] = in_side;
  assign vld_q[0]  = in_valid;

  // One result bit per stage, digit-by-digit square root
  for (genvar j = 0; j < ROOTW; j++) begin : g_stage
    localparam logic [SQIW-1:0] BITV = SQIW'(1) << (SQIW - 2 - 2 * j);
    logic [SQIW-1:0] trial, v_n, r_n;

    always_comb begin
      trial = r_q[j] + BITV;
      if (v_q[j] >= trial) begin
        v_n = v_q[j] - trial;
        r_n = (r_q[j] >> 1) + BITV;
      end else begin
        v_n = v_q[j];
        r_n = r_q[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j+1] <= 1'b0;
      end else if (en) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[j+1]    <= v_n;
        r_q[j+1]    <= r_n;
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign out_valid = vld_q[ROOTW];
  assign root      = r_q[ROOTW][ROOTW-1:0];
  assign out_side  = side_q[ROOTW];

endmodule
`default_nettype wire

// ===== hdl/pdn_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pdn_div
  import pdn_pkg::*;
#(
  parameter int PW = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUMW-1:0]  num,
  input  wire logic [ROOTW-1:0] den,
  input  wire logic [PW-1:0]    in_side,
  output logic [QW-1:0]         quo,
  output logic [PW-1:0]         out_side
);

  logic [NUMW-1:0]  rem_q  [QW+1];
  logic [QW-1:0]    q_q    [QW+1];
  logic [ROOTW-1:0] d_q    [QW+1];
  logic [PW-1:0]    side_q [QW+1];

  assign rem_q[0]  = num;
  assign q_q[0]    = '0;
  assign d_q[0]    = den;
  assign side_q[0] = in_side;

  // Restoring division, one quotient bit per stage, MSB first
  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int SH = QW - 1 - j;
    logic [NUMW:0]   dsh;
    logic            ge;
    logic [NUMW-1:0] rem_n;
    logic [QW-1:0]   q_n;

    always_comb begin
      dsh   = (NUMW+1)'(d_q[j]) << SH;
      ge    = {1'b0, rem_q[j]} >= dsh;
      rem_n = ge ? NUMW'({1'b0, rem_q[j]} - dsh) : rem_q[j];
      q_n   = ge ? (q_q[j] | (QW'(1) << SH)) : q_q[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j+1]  <= rem_n;
        q_q[j+1]    <= q_n;
        d_q[j+1]    <= d_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign quo      = q_q[QW];
  assign out_side = side_q[QW];

endmodule
`default_nettype wire
